### src/kors_pkg.sv
// Package for the Kepler orbit state rate block: widths, CORDIC table, state codes.
// Used by every module in src; depends on nothing.
package kors_pkg;

  localparam int CordicSteps = 30;
  localparam int AngleBits = 32;
  localparam logic signed [63:0] OneQ30 = 64'sd1073741824;
  localparam logic signed [63:0] CordicGainQ30 = 64'sd652032874;
  localparam logic [31:0] InvTwoPiQ32 = 32'd683565276;

  // register indexes of the configuration port
  localparam logic [2:0] RegEcc = 3'd0;
  localparam logic [2:0] RegSma = 3'd1;
  localparam logic [2:0] RegK = 3'd2;
  localparam logic [2:0] RegRate = 3'd3;
  localparam logic [2:0] RegSteps = 3'd4;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SC_START, OP_SC_STEP, OP_FSTEP, OP_DIV_START, OP_DIV_STEP,
    OP_ESTEP, OP_RADIUS, OP_HALF_START, OP_AT_START, OP_AT_STEP, OP_STORE,
    OP_RATE1, OP_RATE2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       sc_half;
  } cmd_t;

  typedef struct packed {
    logic       full;
  } sts_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0: t = 32'h20000000; 5'd1: t = 32'h12E4051E; 5'd2: t = 32'h09FB385B;
      5'd3: t = 32'h051111D4; 5'd4: t = 32'h028B0D43; 5'd5: t = 32'h0145D7E1;
      5'd6: t = 32'h00A2F61E; 5'd7: t = 32'h00517C55; 5'd8: t = 32'h0028BE53;
      5'd9: t = 32'h00145F2F; 5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3; 5'd14: t = 32'h0000A2F9;
      5'd15: t = 32'h0000517C; 5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A2F; 5'd19: t = 32'h00000517; 5'd20: t = 32'h0000028B;
      5'd21: t = 32'h00000145; 5'd22: t = 32'h000000A2; 5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000028; 5'd25: t = 32'h00000014; 5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005; 5'd28: t = 32'h00000002; 5'd29: t = 32'h00000001;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

endpackage

### src/kors_dp.sv
// Datapath: CORDIC rotator/vectorer, restoring divider, multipliers, sample history.
// Depends on kors_pkg; driven by kors_ctrl through cmd_t.
module kors_dp import kors_pkg::*; (
  input  logic        clk,
  input  logic [23:0] ecc,
  input  logic [31:0] sma,
  input  logic [31:0] kfac,
  input  logic [31:0] rscale,
  input  logic [31:0] in_m,
  input  logic [31:0] in_t,
  input  cmd_t        cmd,
  input  logic [4:0]  step,
  input  logic        rst_hist,
  output sts_t        sts,
  output logic [31:0] o_time,
  output logic [31:0] o_rad,
  output logic [31:0] o_ang,
  output logic [31:0] o_rrate,
  output logic [31:0] o_arate
);

  logic [31:0] e_r, m_r, tt_r;
  logic signed [63:0] x_r, y_r, z_r;
  logic flip_r;
  logic signed [63:0] s_r, c_r, es_r, fp_r;
  logic [63:0] num_r, rem_r, quo_r;
  logic neg_r;
  logic [31:0] rad_r, ang_r, tm_r, pend_rad_r;
  logic [31:0] rh_r [3], ah_r [3], th_r [3];
  logic [1:0] slot_r, held_r;
  logic [31:0] rr_r, ar_r;

  // operand magnitudes stay below 2^32, so one 32x32 product suffices
  function automatic logic signed [63:0] smul_rnd(input logic signed [63:0] a,
      input logic [31:0] b, input int s);
    logic [31:0] mag;
    logic [64:0] p;
    mag = a[63] ? 32'(-a) : a[31:0];
    p = ({33'd0, mag} * {33'd0, b} + (65'd1 << (s - 1))) >> s;
    return a[63] ? -$signed(p[63:0]) : $signed(p[63:0]);
  endfunction

  function automatic logic [31:0] sat(input logic signed [63:0] r);
    if (r > 64'sd2147483647) return 32'h7FFFFFFF;
    if (r < -64'sd2147483648) return 32'h80000000;
    return r[31:0];
  endfunction

  logic [1:0] middle, newest;
  logic [31:0] ang_in;
  logic signed [63:0] ecos, fp_c;
  always_comb begin
    middle = (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
    newest = (slot_r == 2'd0) ? 2'd2 : slot_r - 2'd1;
    ang_in = cmd.sc_half ? {1'b0, e_r[31:1]} : e_r;
    ecos = smul_rnd(c_r, {8'd0, ecc}, 24);
    fp_c = OneQ30 - ecos;
    if (fp_c < 64'sd1) fp_c = 64'sd1;
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        m_r <= in_m; tt_r <= in_t;
      end
      OP_SC_START: begin
        flip_r <= ang_in[31] ^ ang_in[30];
        z_r <= 64'($signed((ang_in[31] ^ ang_in[30]) ? ang_in + 32'h80000000 : ang_in));
        x_r <= CordicGainQ30; y_r <= 64'sd0;
      end
      OP_SC_STEP: begin
        if (!z_r[63]) begin
          x_r <= x_r - (y_r >>> step); y_r <= y_r + (x_r >>> step);
          z_r <= z_r - 64'(atan_turn(step));
        end else begin
          x_r <= x_r + (y_r >>> step); y_r <= y_r - (x_r >>> step);
          z_r <= z_r + 64'(atan_turn(step));
        end
        if (step == 5'(CordicSteps - 1)) begin
          s_r <= flip_r ? -(y_r + (z_r[63] ? -(x_r >>> step) : (x_r >>> step)))
                        :  (y_r + (z_r[63] ? -(x_r >>> step) : (x_r >>> step)));
          c_r <= flip_r ? -(x_r - (z_r[63] ? -(y_r >>> step) : (y_r >>> step)))
                        :  (x_r - (z_r[63] ? -(y_r >>> step) : (y_r >>> step)));
        end
      end
      OP_FSTEP: begin
        es_r <= smul_rnd(s_r, {8'd0, ecc}, 24);
        fp_r <= fp_c;
      end
      OP_DIV_START: begin
        // Kepler residual in angle units, then its magnitude as the dividend
        logic signed [63:0] ff;
        ff = 64'($signed(e_r - m_r)) - smul_rnd(es_r, InvTwoPiQ32, 30);
        neg_r <= ff[63];
        num_r <= (ff[63] ? 64'(-ff) : 64'(ff)) << 30;
        rem_r <= 64'd0; quo_r <= 64'd0;
      end
      OP_DIV_STEP: begin
        // two restoring bits per cycle
        logic [64:0] r1, r2;
        logic [63:0] q1;
        r1 = {rem_r, num_r[63]};
        q1 = {quo_r[62:0], r1 >= {1'b0, fp_r}};
        if (r1 >= {1'b0, fp_r}) r1 = r1 - {1'b0, fp_r};
        r2 = {r1[63:0], num_r[62]};
        quo_r <= {q1[62:0], r2 >= {1'b0, fp_r}};
        rem_r <= (r2 >= {1'b0, fp_r}) ? 64'(r2 - {1'b0, fp_r}) : r2[63:0];
        num_r <= {num_r[61:0], 2'b00};
      end
      OP_RADIUS: fp_r <= fp_c;
      OP_AT_START: begin
        logic signed [63:0] yy;
        logic [64:0] pr;
        yy = smul_rnd(s_r, kfac, 24);
        // radius from the denominator held since the radius step
        pr = ({33'd0, sma} * {33'd0, fp_r[31:0]} + 65'd536870912) >> 30;
        pend_rad_r <= (pr > 65'hFFFFFFFF) ? 32'hFFFFFFFF : pr[31:0];
        if (c_r[63]) begin
          x_r <= -c_r; y_r <= -yy; z_r <= 64'h80000000;
        end else begin
          x_r <= c_r; y_r <= yy; z_r <= 64'd0;
        end
        flip_r <= (c_r == 0) && (yy == 0);
      end
      OP_AT_STEP: begin
        if (y_r > 0) begin
          x_r <= x_r + (y_r >>> step); y_r <= y_r - (x_r >>> step);
          z_r <= 64'(z_r[31:0] + atan_turn(step));
        end else begin
          x_r <= x_r - (y_r >>> step); y_r <= y_r + (x_r >>> step);
          z_r <= 64'(z_r[31:0] - atan_turn(step));
        end
      end
      OP_STORE: begin
        rh_r[slot_r] <= pend_rad_r;
        ah_r[slot_r] <= flip_r ? 32'd0 : {z_r[30:0], 1'b0};
        th_r[slot_r] <= tt_r;
      end
      OP_RATE1: begin
        rr_r <= sat(smul_rnd(64'($signed({1'b0, rh_r[newest]})) -
                    64'($signed({1'b0, rh_r[slot_r]})), rscale, 16));
        ar_r <= sat(smul_rnd(64'($signed(ah_r[newest] - ah_r[slot_r])), rscale, 16));
        rad_r <= rh_r[middle]; ang_r <= ah_r[middle]; tm_r <= th_r[middle];
      end
      default: ;
    endcase
  end

  // history bookkeeping: slot pointer, fill count and the Newton estimate
  always_ff @(posedge clk) begin
    if (rst_hist) begin
      slot_r <= 2'd0; held_r <= 2'd0; e_r <= 32'd0;
    end else if (cmd.op == OP_STORE) begin
      slot_r <= (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
      if (held_r != 2'd3) held_r <= held_r + 2'd1;
    end else if (cmd.op == OP_ESTEP) begin
      e_r <= neg_r ? e_r + quo_r[31:0] : e_r - quo_r[31:0];
    end
  end

  // after the store the slot has advanced: newest is slot-1, middle slot-2, oldest slot
  assign sts.full = (held_r == 2'd3);
  assign o_time = tm_r;
  assign o_rad = rad_r;
  assign o_ang = ang_r;
  assign o_rrate = rr_r;
  assign o_arate = ar_r;
endmodule

### src/kors_ctrl.sv
// Controller: sequences Newton solve, radius, half-angle CORDIC, arctangent, store, rate.
// Depends on kors_pkg; commands kors_dp.
module kors_ctrl import kors_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [5:0] steps,
  input  logic       in_fire,
  input  logic       out_fire,
  input  sts_t       sts,
  output logic       busy,
  output logic       out_valid,
  output cmd_t       cmd,
  output logic [4:0] step
);

  typedef enum logic [3:0] {
    S_IDLE, S_NT_SC0, S_NT_SC, S_NT_F, S_NT_D0, S_NT_D, S_NT_E,
    S_R_SC0, S_R_SC, S_R_RAD, S_H_SC0, S_H_SC, S_AT0, S_AT, S_STORE, S_RATE
  } state_t;

  state_t state_r, state_nxt;
  logic [5:0] it_r, it_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic ov_r, ov_nxt;

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign step = cnt_r;

  always_comb begin
    state_nxt = state_r; it_nxt = it_r; cnt_nxt = cnt_r; ov_nxt = ov_r;
    cmd.op = OP_NONE; cmd.sc_half = 1'b0;
    if (out_fire) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.op = OP_LOAD; it_nxt = 6'd0;
        state_nxt = (steps == 6'd0) ? S_R_SC0 : S_NT_SC0;
      end
      S_NT_SC0, S_R_SC0, S_H_SC0: begin
        cmd.op = OP_SC_START; cmd.sc_half = (state_r == S_H_SC0); cnt_nxt = 5'd0;
        state_nxt = (state_r == S_NT_SC0) ? S_NT_SC : (state_r == S_R_SC0) ? S_R_SC : S_H_SC;
      end
      S_NT_SC, S_R_SC, S_H_SC: begin
        cmd.op = OP_SC_STEP; cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(CordicSteps - 1))
          state_nxt = (state_r == S_NT_SC) ? S_NT_F : (state_r == S_R_SC) ? S_R_RAD : S_AT0;
      end
      S_NT_F: begin cmd.op = OP_FSTEP; state_nxt = S_NT_D0; end
      S_NT_D0: begin cmd.op = OP_DIV_START; cnt_nxt = 5'd0; state_nxt = S_NT_D; end
      S_NT_D: begin
        cmd.op = OP_DIV_STEP; cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) state_nxt = S_NT_E;
      end
      S_NT_E: begin
        cmd.op = OP_ESTEP; it_nxt = it_r + 6'd1;
        state_nxt = (it_r + 6'd1 >= steps) ? S_R_SC0 : S_NT_SC0;
      end
      S_R_RAD: begin cmd.op = OP_RADIUS; state_nxt = S_H_SC0; end
      S_AT0: begin cmd.op = OP_AT_START; cnt_nxt = 5'd0; state_nxt = S_AT; end
      S_AT: begin
        cmd.op = OP_AT_STEP; cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(CordicSteps - 1)) state_nxt = S_STORE;
      end
      S_STORE: begin cmd.op = OP_STORE; state_nxt = S_RATE; end
      // hold here while the previous result still waits in the output register
      S_RATE: begin
        if (!sts.full) begin
          state_nxt = S_IDLE;
        end else if (!ov_r || out_fire) begin
          cmd.op = OP_RATE1; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; it_r <= 6'd0; cnt_r <= 5'd0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; it_r <= it_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
    end
  end
endmodule

### src/kepler_orbit_state_rates_top.sv
// Kepler orbit state rates: one item at a time.
// Processing time per item grows with the number of Newton steps and is set by the
// shared 30-step CORDIC and the two-bit-per-cycle divider.
// Items do not overlap: a new one is taken only in the idle state; the next item is taken while
// a result waits in the output register, and its result holds until that one leaves.
// Synchronous active-low reset restores registers and empties the history.
module kepler_orbit_state_rates_top import kors_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // mean_anomaly[31:0], time_tag[63:32]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // sample_time, radius, true_anomaly, radial_rate, angular_rate
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata
);

  logic [23:0] ecc_r;
  logic [31:0] sma_r, k_r, rs_r;
  logic [5:0] st_r;
  cmd_t cmd;
  sts_t sts;
  logic [4:0] step;
  logic busy, in_fire, out_fire;
  logic [31:0] t, r, a, rr, ar;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecc_r <= 24'd6507988; sma_r <= 32'd729284198; k_r <= 32'd25638000;
      rs_r <= 32'd65536; st_r <= 6'd20;
    end else if (cfg_we) begin
      case (cfg_addr)
        RegEcc: ecc_r <= cfg_wdata[23:0];
        RegSma: sma_r <= cfg_wdata;
        RegK: k_r <= cfg_wdata;
        RegRate: rs_r <= cfg_wdata;
        RegSteps: st_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  kors_ctrl u_ctrl (.clk, .rst_n, .steps(st_r), .in_fire, .out_fire, .sts,
                    .busy, .out_valid(out_tvalid), .cmd, .step);

  kors_dp u_dp (.clk, .ecc(ecc_r), .sma(sma_r), .kfac(k_r), .rscale(rs_r),
                .in_m(in_tdata[31:0]), .in_t(in_tdata[63:32]), .cmd, .step,
                .rst_hist(!rst_n), .sts, .o_time(t), .o_rad(r), .o_ang(a),
                .o_rrate(rr), .o_arate(ar));

  assign out_tdata = {ar, rr, a, r, t};
endmodule

### sim/kors_checker.sv
// Checker for the Kepler orbit state rate block: follows register writes and input items,
// predicts each orbit sample result and compares it with the output stream.
// Depends on kors_pkg for register indexes, CORDIC constants and the arctangent table.
module kors_checker import kors_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [63:0]  in_tdata,   // mean_anomaly[31:0], time_tag[63:32]
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [159:0] out_tdata,  // sample_time, radius, true_anomaly, radial_rate, angular_rate
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  output int           errors,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // packed so that sample_time sits in the lowest bits, as on out_tdata
  typedef struct packed {
    logic [31:0] angular_rate;
    logic [31:0] radial_rate;
    logic [31:0] true_anomaly;
    logic [31:0] radius;
    logic [31:0] sample_time;
  } orbit_sample_t;

  orbit_sample_t expected_samples[$];

  // register copies
  bit [23:0] ecc;
  bit [31:0] sma, k_factor, rate_scale;
  bit [5:0]  steps;

  // solver state and three-entry history
  bit [31:0] last_e;
  bit [31:0] hist_radius[3], hist_angle[3], hist_time[3];
  int        slot_next, held;

  initial errors = 0;
  assign pending = expected_samples.size();

  // signed times unsigned, shifted right by s, rounded half away from zero
  function automatic longint mul_round(longint a, bit [63:0] b, int s);
    bit [63:0] mag, r;
    mag = (a < 0) ? -a : a;
    r = (mag * b + (64'd1 << (s - 1))) >> s;
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void sin_cos_q30(input bit [31:0] ang, output longint sn, output longint cs);
    bit [31:0] u, t;
    bit        flip;
    longint    z, x, y, nx, ny;
    t = ang + 32'h40000000;
    flip = t[31];
    u = flip ? ang + 32'h80000000 : ang;
    z = longint'(signed'(u));
    x = CordicGainQ30;
    y = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= longint'(atan_turn(i[4:0]));
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += longint'(atan_turn(i[4:0]));
      end
      x = nx; y = ny;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic bit [31:0] vector_angle(longint y, longint x);
    bit [31:0] z;
    longint    nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x; y = -y; z = 32'h80000000;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_turn(i[4:0]);
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_turn(i[4:0]);
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  // 1 - e*cos E, clamped to at least one LSB
  function automatic longint denominator(longint c);
    longint fp;
    fp = OneQ30 - mul_round(c, {40'd0, ecc}, 24);
    return (fp < 1) ? 1 : fp;
  endfunction

  function automatic bit [31:0] scaled_rate(longint d);
    longint r;
    r = mul_round(d, {32'd0, rate_scale}, 16);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // solve one sample, update the history, return whether a result follows
  function automatic bit predict_sample(bit [31:0] mean, bit [31:0] tag, output orbit_sample_t r);
    bit [31:0] e, w;
    bit [63:0] mag, q, rad;
    longint    sn, cs, hs, hc, f, fp;
    int        slot, oldest, middle;
    e = last_e;
    for (int n = 0; n < steps; n++) begin
      w = e - mean;
      sin_cos_q30(e, sn, cs);
      f = longint'(signed'(w)) - mul_round(mul_round(sn, {40'd0, ecc}, 24), {32'd0, InvTwoPiQ32}, 30);
      fp = denominator(cs);
      mag = (f < 0) ? -f : f;
      q = ((mag / fp) << 30) + ((mag % fp) << 30) / fp;
      if (f < 0) q = -q;
      e = e - q[31:0];
    end
    last_e = e;
    sin_cos_q30(e, sn, cs);
    fp = denominator(cs);
    rad = ({32'd0, sma} * fp + (64'd1 << 29)) >> 30;
    if (rad > 64'hFFFFFFFF) rad = 64'hFFFFFFFF;
    sin_cos_q30(e >> 1, hs, hc);
    slot = slot_next;
    hist_radius[slot] = rad[31:0];
    hist_angle[slot] = vector_angle(mul_round(hs, {32'd0, k_factor}, 24), hc) << 1;
    hist_time[slot] = tag;
    slot_next = (slot + 1) % 3;
    if (held < 3) held++;
    if (held < 3) return 0;
    oldest = (slot + 1) % 3;
    middle = (slot + 2) % 3;
    r.sample_time = hist_time[middle];
    r.radius = hist_radius[middle];
    r.true_anomaly = hist_angle[middle];
    r.radial_rate = scaled_rate(longint'(hist_radius[slot]) - longint'(hist_radius[oldest]));
    r.angular_rate = scaled_rate(longint'(signed'(hist_angle[slot] - hist_angle[oldest])));
    return 1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    errors++;
  endtask

  // follow registers and items, compare results
  always @(posedge clk) begin
    orbit_sample_t exp_s, got_s;
    if (!rst_n) begin
      ecc = 24'd6507988; sma = 32'd729284198; k_factor = 32'd25638000;
      rate_scale = 32'd65536; steps = 6'd20;
      last_e = 0; slot_next = 0; held = 0;
      expected_samples.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          RegEcc:   ecc = cfg_wdata[23:0];
          RegSma:   sma = cfg_wdata;
          RegK:     k_factor = cfg_wdata;
          RegRate:  rate_scale = cfg_wdata;
          RegSteps: steps = cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (predict_sample(in_tdata[31:0], in_tdata[63:32], exp_s))
          expected_samples.push_back(exp_s);
      end
      if (out_tvalid && out_tready) begin
        got_s = out_tdata;
        if (expected_samples.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $realtime, out_tdata);
          errors++;
        end else begin
          exp_s = expected_samples.pop_front();
          if (got_s.sample_time != exp_s.sample_time)
            report_mismatch("sample_time", exp_s.sample_time, got_s.sample_time);
          if (got_s.radius != exp_s.radius)
            report_mismatch("radius", exp_s.radius, got_s.radius);
          if (got_s.true_anomaly != exp_s.true_anomaly)
            report_mismatch("true_anomaly", exp_s.true_anomaly, got_s.true_anomaly);
          if (got_s.radial_rate != exp_s.radial_rate)
            report_mismatch("radial_rate", exp_s.radial_rate, got_s.radial_rate);
          if (got_s.angular_rate != exp_s.angular_rate)
            report_mismatch("angular_rate", exp_s.angular_rate, got_s.angular_rate);
        end
      end
    end
  end

endmodule

### sim/tb.sv
// Testbench top for kepler_orbit_state_rates_top: clock, reset, register phases,
// mean anomaly stimulus and output back-pressure. Depends on kors_pkg and kors_checker.
module tb import kors_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;   // mean_anomaly[31:0], time_tag[63:32]
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [159:0] out_tdata;       // sample_time, radius, true_anomaly, radial_rate, angular_rate
  logic         cfg_we = 0;
  logic [2:0]   cfg_addr = '0;
  logic [31:0]  cfg_wdata = '0;

  int errors, pending;
  bit steady = 0;       // no idling on either side
  bit hold_request = 0; // ask the receiver for a long hold-off
  bit [31:0] mean_now, tag_now;

  kepler_orbit_state_rates_top DUT (.*);
  kors_checker checker_i (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("tb: done, errors");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        hold_left = 6000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 0;
      end else begin
        out_tready <= steady ? 1'b1 : ($urandom_range(99) >= 33);
      end
    end
  end

  task automatic send_item(bit [31:0] mean, bit [31:0] tag);
    while (!steady && $urandom_range(99) < 33) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {tag, mean};
    do @(posedge clk); while (!in_tready);
  endtask

  // hold valid low and wait until no expected result is pending
  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] e, logic [31:0] a, logic [31:0] k, logic [31:0] r,
                          logic [31:0] n);
    write_reg(RegEcc, e);
    write_reg(RegSma, a);
    write_reg(RegK, k);
    write_reg(RegRate, r);
    write_reg(RegSteps, n);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // mostly a smooth orbit walk, sometimes a jump anywhere
  task automatic random_items(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 65) mean_now = mean_now + $urandom_range(32'h04000000);
      else mean_now = $urandom;
      if ($urandom_range(99) < 80) tag_now = tag_now + $urandom_range(1, 16);
      else tag_now = $urandom;
      send_item(mean_now, tag_now);
    end
  endtask

  initial begin
    bit [31:0] corners[12];
    corners = '{32'h0, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h40000000,
                32'hC0000000, 32'h00000001, 32'hBFFFFFFF, 32'h55555555, 32'hAAAAAAAA,
                32'h20000000, 32'hE0000000};
    mean_now = 0;
    tag_now = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed corners at reset settings
    for (int i = 0; i < 12; i++) send_item(corners[i], (i % 2) ? 32'hFFFFFFFF : 32'h0 + i);
    random_items(8);
    hold_request = 1;
    random_items(50);
    drain();

    // upper extremes: saturating radius and rates, most Newton steps
    set_regs(32'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd63);
    for (int i = 0; i < 6; i++) send_item(corners[i], 32'h80000000 + i);
    random_items(8);
    drain();

    // lower extremes: circular orbit, zero factor, one step
    set_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'd1);
    for (int i = 0; i < 6; i++) send_item(corners[i], i);
    steady = 1;
    random_items(40);
    steady = 0;
    drain();

    // random settings, mostly few steps
    for (int p = 0; p < 5; p++) begin
      set_regs($urandom, $urandom, $urandom_range(32'h04000000), $urandom_range(32'h00100000),
               (p == 4) ? $urandom_range(1, 63) : $urandom_range(1, 12));
      random_items(25);
      if (p == 2) begin
        in_tvalid <= 0;
        @(posedge clk);
        wait (pending == 0);
      end
      random_items(25);
      drain();
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
